// ===== rtl/core/gdad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_pkg: shared types and constants of the date register
// Field widths, calendar constants, microcode word layout and the flags that
// the datapath returns to the sequencer.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // field widths
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned OffW   = 23;

  // signed day number, wide enough for any stored date plus any offset
  localparam int unsigned DaysW = 25;

  // shared constant multiplier
  localparam int unsigned MulAW = 22;
  localparam int unsigned MulKW = 13;
  localparam int unsigned ProdW = MulAW + MulKW;

  // quotient of a divide by 100 through the reciprocal
  localparam int unsigned Q100W       = 8;
  localparam int unsigned Recip100Sh  = 19;
  localparam int unsigned RecipYearSh = 20;

  // microcode address width
  localparam int unsigned PcW = 5;

  // calendar constants
  localparam logic [YearW-1:0]         YearMax   = 14'd9999;
  localparam logic signed [DaysW-1:0]  DaysTotal = 25'sd3652425;
  localparam logic [MonthW-1:0]        MonthJan  = 4'd1;
  localparam logic [MonthW-1:0]        MonthDec  = 4'd12;

  // multiplier constants: days per year, 2^19/100 and 2^20*400/146097
  localparam logic [MulKW-1:0] KYearDays  = 13'd365;
  localparam logic [MulKW-1:0] KRecip100  = 13'd5243;
  localparam logic [MulKW-1:0] KRecipYear = 13'd2871;

  // microcode entry points
  localparam logic [PcW-1:0] EntrySet = 5'd0;
  localparam logic [PcW-1:0] EntryAdd = 5'd4;

  // command codes
  localparam logic CmdSet = 1'b0;
  localparam logic CmdAdd = 1'b1;

  // datapath operations
  typedef enum logic [4:0] {
    OP_LOAD_SET,
    OP_LOAD_ADD,
    OP_LEAP_A,
    OP_LEAP_B,
    OP_CHECK_SET,
    OP_FWD_MON,
    OP_DBY_A,
    OP_DBY_B,
    OP_DBY_C,
    OP_DBY_D,
    OP_ADD_T,
    OP_RANGE,
    OP_EST,
    OP_SET_Y,
    OP_UP_CHK,
    OP_DN_CHK,
    OP_REV_MON,
    OP_COMMIT,
    OP_FAIL
  } op_e;

  // branch conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_FWD_MON,
    COND_OUT_RANGE,
    COND_UP,
    COND_DN,
    COND_REV_MON
  } cond_e;

  // one microcode word
  typedef struct packed {
    op_e            op;
    logic           plus1;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           last;
  } ctrl_word_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic fwd_mon;
    logic out_range;
    logic up;
    logic dn;
    logic rev_mon;
  } dp_flags_t;

  // length of a month, month codes outside 1 to 12 read as 31
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/gdad_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_seq: microcode sequencer of the date register
// Holds the step counter and the control store, picks the next step from the
// datapath flags and stops on the last step of a program.
// ----------------------------------------------------------------------------
module gdad_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   command_i,
  input  logic                   hold_i,
  input  gdad_pkg::dp_flags_t    flags_i,
  output gdad_pkg::ctrl_word_t   cw_o,
  output logic                   step_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import gdad_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  logic           busy_q, busy_d;
  ctrl_word_t     cw;
  logic           taken;

  function automatic ctrl_word_t mk_cw(input op_e op, input logic plus1,
                                       input cond_e cond,
                                       input logic [PcW-1:0] target,
                                       input logic last);
    ctrl_word_t w;
    w.op     = op;
    w.plus1  = plus1;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // control store
  always_comb begin
    case (pc_q)
      // set: load, leap test, check and store
      5'd0:  cw = mk_cw(OP_LOAD_SET,  1'b0, COND_NONE,      5'd0,  1'b0);
      5'd1:  cw = mk_cw(OP_LEAP_A,    1'b0, COND_NONE,      5'd0,  1'b0);
      5'd2:  cw = mk_cw(OP_LEAP_B,    1'b0, COND_NONE,      5'd0,  1'b0);
      5'd3:  cw = mk_cw(OP_CHECK_SET, 1'b0, COND_NONE,      5'd0,  1'b1);
      // add: day number of the stored date plus offset
      5'd4:  cw = mk_cw(OP_LOAD_ADD,  1'b0, COND_NONE,      5'd0,  1'b0);
      5'd5:  cw = mk_cw(OP_LEAP_A,    1'b0, COND_NONE,      5'd0,  1'b0);
      5'd6:  cw = mk_cw(OP_LEAP_B,    1'b0, COND_NONE,      5'd0,  1'b0);
      5'd7:  cw = mk_cw(OP_FWD_MON,   1'b0, COND_FWD_MON,   5'd7,  1'b0);
      5'd8:  cw = mk_cw(OP_DBY_A,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd9:  cw = mk_cw(OP_DBY_B,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd10: cw = mk_cw(OP_DBY_C,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd11: cw = mk_cw(OP_DBY_D,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd12: cw = mk_cw(OP_ADD_T,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd13: cw = mk_cw(OP_RANGE,     1'b0, COND_OUT_RANGE, 5'd30, 1'b0);
      // year estimate and correction
      5'd14: cw = mk_cw(OP_EST,       1'b0, COND_NONE,      5'd0,  1'b0);
      5'd15: cw = mk_cw(OP_SET_Y,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd16: cw = mk_cw(OP_DBY_A,     1'b1, COND_NONE,      5'd0,  1'b0);
      5'd17: cw = mk_cw(OP_DBY_B,     1'b1, COND_NONE,      5'd0,  1'b0);
      5'd18: cw = mk_cw(OP_DBY_C,     1'b1, COND_NONE,      5'd0,  1'b0);
      5'd19: cw = mk_cw(OP_DBY_D,     1'b1, COND_NONE,      5'd0,  1'b0);
      5'd20: cw = mk_cw(OP_UP_CHK,    1'b0, COND_UP,        5'd16, 1'b0);
      5'd21: cw = mk_cw(OP_DBY_A,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd22: cw = mk_cw(OP_DBY_B,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd23: cw = mk_cw(OP_DBY_C,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd24: cw = mk_cw(OP_DBY_D,     1'b0, COND_NONE,      5'd0,  1'b0);
      5'd25: cw = mk_cw(OP_DN_CHK,    1'b0, COND_DN,        5'd21, 1'b0);
      // month and day within the year
      5'd26: cw = mk_cw(OP_LEAP_A,    1'b0, COND_NONE,      5'd0,  1'b0);
      5'd27: cw = mk_cw(OP_LEAP_B,    1'b0, COND_NONE,      5'd0,  1'b0);
      5'd28: cw = mk_cw(OP_REV_MON,   1'b0, COND_REV_MON,   5'd28, 1'b0);
      5'd29: cw = mk_cw(OP_COMMIT,    1'b0, COND_NONE,      5'd0,  1'b1);
      5'd30: cw = mk_cw(OP_FAIL,      1'b0, COND_NONE,      5'd0,  1'b1);
      default: cw = mk_cw(OP_FAIL,    1'b0, COND_NONE,      5'd0,  1'b1);
    endcase
  end

  // branch condition
  always_comb begin
    case (cw.cond)
      COND_FWD_MON:   taken = flags_i.fwd_mon;
      COND_OUT_RANGE: taken = flags_i.out_range;
      COND_UP:        taken = flags_i.up;
      COND_DN:        taken = flags_i.dn;
      COND_REV_MON:   taken = flags_i.rev_mon;
      default:        taken = 1'b0;
    endcase
  end

  // a finishing step waits while the output word is still held
  assign step_o = busy_q && !(cw.last && hold_i);
  assign done_o = step_o && cw.last;
  assign busy_o = busy_q;
  assign cw_o   = cw;

  // next step
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = (command_i == CmdAdd) ? EntryAdd : EntrySet;
      busy_d = 1'b1;
    end else if (step_o) begin
      if (cw.last) begin
        busy_d = 1'b0;
      end else if (taken) begin
        pc_d = cw.target;
      end else begin
        pc_d = pc_q + PcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= EntrySet;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== rtl/core/gdad_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_dp: datapath of the date register
// Working registers, one shared constant multiplier, the stored date and the
// ok flag; each microcode operation updates them for one step.
// ----------------------------------------------------------------------------
module gdad_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [gdad_pkg::YearW-1:0]    set_year_i,
  input  logic [gdad_pkg::MonthW-1:0]   set_month_i,
  input  logic [gdad_pkg::DayW-1:0]     set_day_i,
  input  logic signed [gdad_pkg::OffW-1:0] day_offset_i,
  input  gdad_pkg::ctrl_word_t          cw_i,
  input  logic                          step_i,
  output gdad_pkg::dp_flags_t           flags_o,
  output logic                          ok_o,
  output logic [gdad_pkg::YearW-1:0]    cur_year_o,
  output logic [gdad_pkg::MonthW-1:0]   cur_month_o,
  output logic [gdad_pkg::DayW-1:0]     cur_day_o
);
  import gdad_pkg::*;

  // captured command word
  logic [YearW-1:0]        set_year_q;
  logic [MonthW-1:0]       set_month_q;
  logic [DayW-1:0]         set_day_q;
  logic signed [OffW-1:0]  off_q;

  // working registers
  logic [YearW-1:0]        y_q, y_d;
  logic signed [DaysW-1:0] n_q, n_d;
  logic signed [DaysW-1:0] t_q, t_d;
  logic [ProdW-1:0]        p_q, p_d;
  logic [MonthW-1:0]       m_q, m_d;
  logic                    leap_q, leap_d;

  // stored date
  logic [YearW-1:0]        year_q, year_d;
  logic [MonthW-1:0]       month_q, month_d;
  logic [DayW-1:0]         day_q, day_d;
  logic                    ok_q, ok_d;

  logic [YearW:0]          yy;
  logic [YearW:0]          yy_q4;
  logic [YearW:0]          yy_q400;
  logic [MulAW-1:0]        mul_a;
  logic [MulKW-1:0]        mul_k;
  logic [ProdW-1:0]        prod;
  logic [Q100W-1:0]        q100;
  logic [YearW-1:0]        hundreds;
  logic [YearW:0]          y_est;
  logic [DayW-1:0]         dim;
  logic                    set_ok;

  // year operand of the day count, this year or the next
  assign yy      = {1'b0, y_q} + (YearW+1)'(cw_i.plus1);
  assign yy_q4   = (yy + (YearW+1)'(3)) >> 2;
  assign yy_q400 = (yy + (YearW+1)'(399)) >> 2;

  // shared constant multiplier operands
  always_comb begin
    case (cw_i.op)
      OP_DBY_A: begin
        mul_a = MulAW'(yy);
        mul_k = KYearDays;
      end
      OP_DBY_B: begin
        mul_a = MulAW'(yy + (YearW+1)'(99));
        mul_k = KRecip100;
      end
      OP_DBY_C: begin
        mul_a = MulAW'(yy_q400);
        mul_k = KRecip100;
      end
      OP_LEAP_A: begin
        mul_a = MulAW'(y_q);
        mul_k = KRecip100;
      end
      OP_EST: begin
        mul_a = n_q[MulAW-1:0];
        mul_k = KRecipYear;
      end
      default: begin
        mul_a = '0;
        mul_k = '0;
      end
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_k);

  // quotients read back from the product register
  assign q100     = p_q[Recip100Sh +: Q100W];
  assign hundreds = YearW'({q100, 6'b0}) + YearW'({q100, 5'b0}) + YearW'({q100, 2'b0});
  assign y_est    = p_q[RecipYearSh +: (YearW+1)];

  // month length for the month counter, and the set check
  assign dim    = month_days(m_q, leap_q);
  assign set_ok = (set_year_q <= YearMax) && (set_month_q inside {[MonthJan:MonthDec]}) &&
                  (set_day_q != '0) && (set_day_q <= month_days(set_month_q, leap_q));

  // flags for the branch conditions
  assign flags_o.fwd_mon   = (m_q < month_q);
  assign flags_o.out_range = (n_q < 0) || (n_q >= DaysTotal);
  assign flags_o.up        = (y_q < YearMax) && (t_q <= n_q);
  assign flags_o.dn        = (y_q != '0) && (t_q > n_q);
  assign flags_o.rev_mon   = (m_q < MonthDec) && (n_q >= $signed(DaysW'(dim)));

  // step operations
  always_comb begin
    y_d     = y_q;
    n_d     = n_q;
    t_d     = t_q;
    p_d     = p_q;
    m_d     = m_q;
    leap_d  = leap_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    ok_d    = ok_q;
    case (cw_i.op)
      OP_LOAD_SET: begin
        y_d = set_year_q;
      end
      OP_LOAD_ADD: begin
        y_d = year_q;
        n_d = DaysW'(off_q) + DaysW'(day_q) - DaysW'(1);
        m_d = MonthJan;
      end
      OP_LEAP_A: begin
        p_d = prod;
      end
      OP_LEAP_B: begin
        leap_d = (y_q[1:0] == 2'b00) && ((hundreds != y_q) || (q100[1:0] == 2'b00));
      end
      OP_CHECK_SET: begin
        ok_d = set_ok;
        if (set_ok) begin
          year_d  = set_year_q;
          month_d = set_month_q;
          day_d   = set_day_q;
        end
      end
      OP_FWD_MON: begin
        if (flags_o.fwd_mon) begin
          n_d = n_q + DaysW'(dim);
          m_d = m_q + MonthW'(1);
        end
      end
      OP_DBY_A: begin
        p_d = prod;
      end
      OP_DBY_B: begin
        t_d = DaysW'(p_q[MulAW-1:0]) + DaysW'(yy_q4);
        p_d = prod;
      end
      OP_DBY_C: begin
        t_d = t_q - DaysW'(q100);
        p_d = prod;
      end
      OP_DBY_D: begin
        t_d = t_q + DaysW'(q100);
      end
      OP_ADD_T: begin
        n_d = n_q + t_q;
      end
      OP_EST: begin
        p_d = prod;
      end
      OP_SET_Y: begin
        y_d = (y_est > (YearW+1)'(YearMax)) ? YearMax : y_est[YearW-1:0];
      end
      OP_UP_CHK: begin
        if (flags_o.up) begin
          y_d = y_q + YearW'(1);
        end
      end
      OP_DN_CHK: begin
        if (flags_o.dn) begin
          y_d = y_q - YearW'(1);
        end else begin
          n_d = n_q - t_q;
          m_d = MonthJan;
        end
      end
      OP_REV_MON: begin
        if (flags_o.rev_mon) begin
          n_d = n_q - DaysW'(dim);
          m_d = m_q + MonthW'(1);
        end
      end
      OP_COMMIT: begin
        year_d  = y_q;
        month_d = m_q;
        day_d   = n_q[DayW-1:0] + DayW'(1);
        ok_d    = 1'b1;
      end
      OP_FAIL: begin
        ok_d = 1'b0;
      end
      default: begin
        ok_d = ok_q;
      end
    endcase
  end

  // command capture and working registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      set_year_q  <= set_year_i;
      set_month_q <= set_month_i;
      set_day_q   <= set_day_i;
      off_q       <= day_offset_i;
    end
    if (step_i) begin
      y_q    <= y_d;
      n_q    <= n_d;
      t_q    <= t_d;
      p_q    <= p_d;
      m_q    <= m_d;
      leap_q <= leap_d;
    end
  end

  // stored date and ok flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= '0;
      month_q <= MonthJan;
      day_q   <= DayW'(1);
      ok_q    <= 1'b0;
    end else if (step_i) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      ok_q    <= ok_d;
    end
  end

  assign ok_o        = ok_q;
  assign cur_year_o  = year_q;
  assign cur_month_o = month_q;
  assign cur_day_o   = day_q;

endmodule

// ===== rtl/core/gregorian_date_add_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days: Gregorian date register with set and add-days
// Stores a date of years 0 to 9999; a set word stores a checked date, an add
// word moves the stored date by a signed day count. One result per word.
// ----------------------------------------------------------------------------
//  channel | handshake              | fields
//  --------+------------------------+--------------------------------------------
//  in      | in_valid_i, in_stall_o | command, set_year, set_month, set_day,
//          |                        | day_offset
//  out     | out_valid_o,out_stall_i| ok, cur_year, cur_month, cur_day
//
//  The run time of an add word is set by the month walks of the microcode,
//  one each way, and by the year correction loops over the shared multiplier;
//  a refused add word stops at the range check after the forward month walk.
//  Reset leaves 1 January of year 0 stored and the sequencer idle.
//  A new word is taken once the previous program has finished; a result that
//  waits on out_stall_i holds the last step of the next program.
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [gdad_pkg::YearW-1:0]       set_year_i,
  input  logic [gdad_pkg::MonthW-1:0]      set_month_i,
  input  logic [gdad_pkg::DayW-1:0]        set_day_i,
  input  logic signed [gdad_pkg::OffW-1:0] day_offset_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [gdad_pkg::YearW-1:0]       cur_year_o,
  output logic [gdad_pkg::MonthW-1:0]      cur_month_o,
  output logic [gdad_pkg::DayW-1:0]        cur_day_o
);
  import gdad_pkg::*;

  ctrl_word_t cw;
  dp_flags_t  flags;
  logic       in_accept;
  logic       step;
  logic       busy;
  logic       done;
  logic       hold;
  logic       out_valid_q, out_valid_d;

  // input handshake
  assign in_accept  = in_valid_i && !busy;
  assign in_stall_o = busy;

  // output word still waiting
  assign hold = out_valid_q && out_stall_i;

  gdad_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .command_i (command_i),
    .hold_i    (hold),
    .flags_i   (flags),
    .cw_o      (cw),
    .step_o    (step),
    .busy_o    (busy),
    .done_o    (done)
  );

  gdad_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .set_year_i   (set_year_i),
    .set_month_i  (set_month_i),
    .set_day_i    (set_day_i),
    .day_offset_i (day_offset_i),
    .cw_i         (cw),
    .step_i       (step),
    .flags_o      (flags),
    .ok_o         (ok_o),
    .cur_year_o   (cur_year_o),
    .cur_month_o  (cur_month_o),
    .cur_day_o    (cur_day_o)
  );

  // output valid
  always_comb begin
    out_valid_d = hold;
    if (done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a taken word keeps the input side closed for the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o
  ) else $error("input not closed after a word was taken");

  // the stored date is in range whenever a result is valid
  a_date_legal: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cur_month_o >= MonthJan) && (cur_month_o <= MonthDec) &&
                    (cur_day_o != '0) && (cur_year_o <= YearMax)
  ) else $error("stored date out of range");

  // the stored date moves only with a fresh ok result
  a_date_moves_with_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !$stable({cur_year_o, cur_month_o, cur_day_o}) |-> out_valid_o && ok_o
  ) else $error("stored date changed without an ok result");

endmodule
